@@ hdl/pitp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pitp_pkg
// Shared types and constants for the prefixed integer text parser.
// ----------------------------------------------------------------------------
package pitp_pkg;

	localparam int VALUE_BITS_DEF = 32;

	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 32;
	localparam int ERR_W   = 2;
	localparam int RADIX_W = 2;
	localparam int TUSER_W = ERR_W + RADIX_W;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE   = 8'h31;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_X_LO  = 8'h78;
	localparam logic [CHAR_W-1:0] CH_B_LO  = 8'h62;
	localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_Z_UP  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;
	// Lower-case 'a' minus ten: a letter's digit value is its code minus this.
	localparam logic [CHAR_W:0]   HEX_LETTER_BIAS = 9'd87;

	localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
	localparam logic [ERR_W-1:0] ERR_NODIG = 2'd1;
	localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

	localparam logic [RADIX_W-1:0] RADIX_DEC = 2'd0;
	localparam logic [RADIX_W-1:0] RADIX_HEX = 2'd1;
	localparam logic [RADIX_W-1:0] RADIX_BIN = 2'd2;

	// One character held in the input register.
	typedef struct packed {
		logic              valid;
		logic [CHAR_W-1:0] code;
		logic              last;
	} in_word_t;

endpackage : pitp_pkg
`default_nettype wire

@@ hdl/pitp_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pitp_in_stage
// Input register: captures one character word and holds it until the parse
// core consumes it.
// ----------------------------------------------------------------------------
module pitp_in_stage (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire logic [7:0]               s_axis_tdata,   // [7:0] char_code
	input  wire logic                     s_axis_tlast,   // end_of_text
	output pitp_pkg::in_word_t            word_s1,
	input  wire logic                     advance
);
	import pitp_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] code_s1;
	logic              last_s1;
	logic              load;

	assign s_axis_tready = !valid_s1 || advance;
	assign load          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	assign word_s1 = '{valid: valid_s1, code: code_s1, last: last_s1};

endmodule : pitp_in_stage
`default_nettype wire

@@ hdl/pitp_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pitp_core
// Parse state, one-character step logic and the result register.
// ----------------------------------------------------------------------------
module pitp_core #(
	parameter int VALUE_BITS = pitp_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pitp_pkg::in_word_t            word_s1,
	output logic                               advance,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [pitp_pkg::VALUE_W-1:0]       m_axis_tdata,  // [31:0] parsed_value
	output logic [pitp_pkg::TUSER_W-1:0]       m_axis_tuser   // [1:0] error_code,
	                                                          // [3:2] radix_used
);
	import pitp_pkg::*;

	localparam int VB    = VALUE_BITS;
	localparam int EXT_W = (VB > VALUE_W) ? VB : VALUE_W;

	localparam logic [2:0] MODE_START  = 3'd0;
	localparam logic [2:0] MODE_SECOND = 3'd1;
	localparam logic [2:0] MODE_HEX    = 3'd2;
	localparam logic [2:0] MODE_BIN    = 3'd3;
	localparam logic [2:0] MODE_LEAD   = 3'd4;
	localparam logic [2:0] MODE_DIGITS = 3'd5;
	localparam logic [2:0] MODE_STOP   = 3'd6;

	localparam logic [VB-1:0] MAG_BOUND = {1'b1, {(VB-1){1'b0}}};

	typedef struct packed {
		logic [2:0]        mode;
		logic [CHAR_W-1:0] held;
		logic [VB-1:0]     acc;
		logic              neg;
		logic              exceeded;
		logic              seen;
	} parse_st_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// Decimal digit: accumulate unless the magnitude would pass 2^(VB-1).
	function automatic parse_st_t dec_digit(input parse_st_t st, input logic [CHAR_W-1:0] c);
		parse_st_t      r;
		logic [3:0]     d;
		logic [VB+3:0]  t;
		r    = st;
		d    = 4'(c - CH_ZERO);
		t    = ({4'b0, st.acc} << 3) + ({4'b0, st.acc} << 1) + (VB+4)'(d);
		r.seen = 1'b1;
		if (!st.exceeded) begin
			if (t > {4'b0, MAG_BOUND}) begin
				r.exceeded = 1'b1;
			end else begin
				r.acc = t[VB-1:0];
			end
		end
		return r;
	endfunction

	function automatic parse_st_t dec_feed(input parse_st_t st, input logic [CHAR_W-1:0] c);
		parse_st_t r;
		r = st;
		if (st.mode == MODE_LEAD) begin
			if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
				r = st;
			end else if (c == CH_PLUS || c == CH_MINUS) begin
				r.neg  = (c == CH_MINUS);
				r.mode = MODE_DIGITS;
			end else if (is_digit(c)) begin
				r      = dec_digit(st, c);
				r.mode = MODE_DIGITS;
			end else begin
				r.mode = MODE_STOP;
			end
		end else if (st.mode == MODE_DIGITS) begin
			if (is_digit(c)) begin
				r = dec_digit(st, c);
			end else begin
				r.mode = MODE_STOP;
			end
		end
		return r;
	endfunction

	parse_st_t         st_q;
	parse_st_t         st_step;
	parse_st_t         st_lead;
	logic [CHAR_W-1:0] c;
	logic [CHAR_W-1:0] lc;
	logic [CHAR_W:0]   letter_diff;
	logic [VB-1:0]     hex_d;
	logic [VB-1:0]     mag;
	logic signed [EXT_W-1:0] ext;
	logic [VALUE_W-1:0] value_nx;
	logic [ERR_W-1:0]   err_nx;
	logic [RADIX_W-1:0] radix_nx;
	logic               finish;

	logic               out_valid_q;
	logic [VALUE_W-1:0] value_q;
	logic [ERR_W-1:0]   err_q;
	logic [RADIX_W-1:0] radix_q;

	assign c       = word_s1.code;
	assign advance = word_s1.valid && (!word_s1.last || !out_valid_q || m_axis_tready);
	assign finish  = advance && word_s1.last;

	// Hex digit value; letters and any other byte wrap modulo 2^VB.
	always_comb begin
		lc          = (c >= CH_A_UP && c <= CH_Z_UP) ? c + CASE_GAP : c;
		letter_diff = {1'b0, lc} - HEX_LETTER_BIAS;
		if (is_digit(c)) begin
			hex_d = VB'(c - CH_ZERO);
		end else begin
			hex_d = VB'($signed(letter_diff));
		end
	end

	always_comb begin
		st_step = st_q;
		st_lead = st_q;
		case (st_q.mode)
			MODE_START: begin
				st_step.held = c;
				st_step.mode = MODE_SECOND;
				if (word_s1.last) begin
					st_lead.mode = MODE_LEAD;
					st_step      = dec_feed(st_lead, c);
					st_step.held = c;
				end
			end
			MODE_SECOND: begin
				if (st_q.held == CH_ZERO && c == CH_X_LO) begin
					st_step.mode = MODE_HEX;
				end else if (st_q.held == CH_ZERO && c == CH_B_LO) begin
					st_step.mode = MODE_BIN;
				end else begin
					// The held first character and this one are both fed here.
					st_lead.mode = MODE_LEAD;
					st_step      = dec_feed(dec_feed(st_lead, st_q.held), c);
				end
			end
			MODE_HEX: begin
				st_step.acc = {st_q.acc[VB-5:0], 4'b0} + hex_d;
			end
			MODE_BIN: begin
				st_step.acc = {st_q.acc[VB-2:0], (c == CH_ONE)};
			end
			default: begin
				st_step = dec_feed(st_q, c);
			end
		endcase
	end

	always_comb begin
		mag      = st_step.neg ? (~st_step.acc + VB'(1)) : st_step.acc;
		value_nx = '0;
		err_nx   = ERR_OK;
		radix_nx = RADIX_DEC;
		ext      = EXT_W'($signed(mag));
		if (st_step.mode == MODE_HEX || st_step.mode == MODE_BIN) begin
			ext      = EXT_W'($signed(st_step.acc));
			value_nx = ext[VALUE_W-1:0];
			radix_nx = (st_step.mode == MODE_HEX) ? RADIX_HEX : RADIX_BIN;
		end else if (!st_step.seen) begin
			err_nx = ERR_NODIG;
		end else if (st_step.exceeded || (!st_step.neg && st_step.acc == MAG_BOUND)) begin
			err_nx = ERR_RANGE;
		end else begin
			value_nx = ext[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: MODE_START, default: '0};
		end else if (finish) begin
			st_q <= '{mode: MODE_START, default: '0};
		end else if (advance) begin
			st_q <= st_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			value_q <= value_nx;
			err_q   <= err_nx;
			radix_q <= radix_nx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = value_q;
	assign m_axis_tuser  = {radix_q, err_q};

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> (st_q.mode == MODE_START))
		else $error("parse state not cleared after a result");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q != ERR_OK) |-> (value_q == '0 && radix_q == RADIX_DEC))
		else $error("error result carries a value or radix");

	a_radix_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && radix_q != RADIX_DEC) |-> (err_q == ERR_OK))
		else $error("hex or binary result reports an error");

	a_mag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.mode == MODE_LEAD || st_q.mode == MODE_DIGITS || st_q.mode == MODE_STOP)
		|-> (st_q.acc <= MAG_BOUND))
		else $error("decimal magnitude passed its bound");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !finish)
		else $error("result overwritten while stalled");

endmodule : pitp_core
`default_nettype wire

@@ hdl/prefixed_integer_text_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// prefixed_integer_text_parser
// Reads a character stream and returns the integer that each string spells:
// hex after "0x", binary after "0b", signed decimal otherwise.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                  | tuser                         | tlast
//  s_axis   | in  | [7:0] char_code        | -                             | end_of_text
//  m_axis   | out | [31:0] parsed_value    | [1:0] error_code, [3:2] radix | -
//
// One word per cycle is taken unless a stalled result holds a last word; the
// parse step sits between the input register and the result register, which
// a result word reaches after its last word has passed the input register.
// Reset clears the parse state and both valid flags.
// A stalled result blocks only the last word of the next string; other words
// keep flowing into the parse state.
// ----------------------------------------------------------------------------
module prefixed_integer_text_parser #(
	parameter int VALUE_BITS = pitp_pkg::VALUE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	input  wire logic [7:0]                    s_axis_tdata,  // [7:0] char_code
	input  wire logic                          s_axis_tlast,  // end_of_text
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	output logic [pitp_pkg::VALUE_W-1:0]       m_axis_tdata,  // [31:0] parsed_value
	output logic [pitp_pkg::TUSER_W-1:0]       m_axis_tuser   // [1:0] error_code,
	                                                          // [3:2] radix_used
);
	import pitp_pkg::*;

	in_word_t word_s1;
	logic     advance;

	pitp_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.word_s1       (word_s1),
		.advance       (advance)
	);

	pitp_core #(
		.VALUE_BITS (VALUE_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.word_s1       (word_s1),
		.advance       (advance),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule : prefixed_integer_text_parser
`default_nettype wire
